// ===== rtl/core/mcm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Matrix chain order package
// Default sizes, command codes and the sequencer state type.
// ----------------------------------------------------------------------------
package mcm_pkg;

    localparam int MAX_MATRICES_DEF = 16;
    localparam int DIM_BITS_DEF     = 12;
    localparam int COST_BITS_DEF    = 48;
    localparam int QIDX_W           = 5;

    typedef enum logic
    {
        CMD_LOAD  = 1'b0,
        CMD_QUERY = 1'b1
    } cmd_t;

    typedef enum logic [3:0]
    {
        ST_IDLE,
        ST_DIAG,
        ST_RDI,
        ST_RDJ,
        ST_LATJ,
        ST_RDK,
        ST_EVAL,
        ST_CMP,
        ST_ANS,
        ST_OUT
    } state_t;

endpackage

// ===== rtl/core/mcm_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Matrix chain order channels
// Request channel (load or query) and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface mcm_in_if #(
    parameter int DIM_BITS = mcm_pkg::DIM_BITS_DEF
);
    logic                        valid;
    logic                        ready;
    logic                        cmd;
    logic [DIM_BITS-1:0]         dim;
    logic                        last;
    logic [mcm_pkg::QIDX_W-1:0]  chain_first;
    logic [mcm_pkg::QIDX_W-1:0]  chain_end;

    modport source (output valid, cmd, dim, last, chain_first, chain_end, input ready);
    modport sink   (input valid, cmd, dim, last, chain_first, chain_end, output ready);
endinterface

interface mcm_out_if #(
    parameter int COST_BITS = mcm_pkg::COST_BITS_DEF
);
    logic                        valid;
    logic                        ready;
    logic [COST_BITS-1:0]        cost;
    logic [mcm_pkg::QIDX_W-1:0]  split;
    logic                        saturated;
    logic                        bad_query;

    modport source (output valid, cost, split, saturated, bad_query, input ready);
    modport sink   (input valid, cost, split, saturated, bad_query, output ready);
endinterface

// ===== rtl/core/matrix_chain_order_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Matrix chain multiplication order
// Loads dimensions p0..pn, fills cost/split tables by the interval program,
// returns the chain cost and split, and answers subchain queries.
// ----------------------------------------------------------------------------
//  channel   dir  payload                                   handshake
//  in_ch     in   cmd, dim, last, chain_first, chain_end    valid/ready
//  out_ch    out  cost, split, saturated, bad_query         valid/ready
//
//  A load without last stores its dimension and gives no result; a query reads
//  the tables and waits in ST_OUT for a free result slot, while a rejected one
//  goes straight to the slot. Last load: ST_DIAG per diagonal cell, ST_RDI, ST_RDJ
//  and ST_LATJ per interval to fetch p(i-1) and p(j), and per split candidate
//  ST_RDK (table and p(k) read), ST_EVAL (four-cell saturating chain), ST_CMP (compare).
//  Reset clears control state only; tables are valid after a computation.
//  A held result stalls input acceptance until the result slot frees.
// ----------------------------------------------------------------------------
module matrix_chain_order_dp #(
    parameter int MAX_MATRICES = mcm_pkg::MAX_MATRICES_DEF,
    parameter int DIM_BITS     = mcm_pkg::DIM_BITS_DEF,
    parameter int COST_BITS    = mcm_pkg::COST_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    mcm_in_if.sink    in_ch,
    mcm_out_if.source out_ch
);
    import mcm_pkg::*;

    localparam int NDIMS = MAX_MATRICES + 1;
    localparam int TSIZE = MAX_MATRICES * MAX_MATRICES;
    localparam int IW    = $clog2(MAX_MATRICES + 2);
    localparam int DW    = $clog2(NDIMS);
    localparam int TAW   = $clog2(TSIZE);
    localparam int SW    = $clog2(MAX_MATRICES);
    localparam int CW    = (IW > QIDX_W) ? IW : QIDX_W;

    function automatic logic [TAW-1:0] tidx(input logic [IW-1:0] i, input logic [IW-1:0] j);
        int t;
        t = (int'(i) - 1) * MAX_MATRICES + (int'(j) - 1);
        return TAW'(t);
    endfunction

    state_t state_reg, state_next;

    logic [IW-1:0]        loaded_reg, loaded_next;
    logic [IW-1:0]        len_reg, len_next;
    logic                 ovf_reg, ovf_next;
    logic [IW-1:0]        i_reg, i_next;
    logic [IW-1:0]        k_reg, k_next;
    logic [IW-1:0]        span_reg, span_next;
    logic [1:0]           cnt_reg, cnt_next;
    logic [DIM_BITS-1:0]  di_reg, di_next;
    logic [DIM_BITS-1:0]  dj_reg, dj_next;
    logic [COST_BITS-1:0] best_reg, best_next;
    logic [IW-1:0]        bestk_reg, bestk_next;
    logic                 single_reg, single_next;

    logic                 out_valid_reg, out_valid_next;
    logic [COST_BITS-1:0] out_cost_reg, out_cost_next;
    logic [QIDX_W-1:0]    out_split_reg, out_split_next;
    logic                 out_sat_reg, out_sat_next;
    logic                 out_bad_reg, out_bad_next;

    logic [DIM_BITS-1:0]  dims_mem [NDIMS];
    logic [DIM_BITS-1:0]  dims_rd_reg;
    logic                 dims_we, dims_re;
    logic [DW-1:0]        dims_ra;

    logic [COST_BITS-1:0] cost_mem [TSIZE];
    logic [SW-1:0]        split_mem [TSIZE];
    logic [COST_BITS-1:0] ca_rd_reg, cb_rd_reg;
    logic [SW-1:0]        split_rd_reg;
    logic                 t_we, t_re;
    logic [TAW-1:0]       t_wa, t_ra, t_rb;
    logic [COST_BITS-1:0] t_wcost;
    logic [SW-1:0]        t_wsplit;

    logic [COST_BITS-1:0] c0, c1, c2, c3;
    logic                 v0, v1, v2, v3;

    logic                 accept, slot_free, take, qbad;
    logic [IW-1:0]        j_cur, cnt_new, qa, qb;
    logic [IW:0]          i_end;
    logic [COST_BITS-1:0] nb;
    logic [IW-1:0]        nk;

    assign slot_free = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = (state_reg == ST_IDLE) && slot_free;
    assign accept = in_ch.valid && in_ch.ready;
    assign j_cur = i_reg + span_reg - IW'(1);
    assign i_end = {1'b0, i_reg} + {1'b0, span_reg};
    assign cnt_new = (int'(loaded_reg) < NDIMS) ? loaded_reg + IW'(1) : loaded_reg;
    assign qa = IW'(in_ch.chain_first);
    assign qb = IW'(in_ch.chain_end);
    assign qbad = (len_reg == '0) || (in_ch.chain_first == '0)
                  || (CW'(in_ch.chain_end) > CW'(len_reg))
                  || (in_ch.chain_first > in_ch.chain_end);
    assign take = (k_reg == i_reg) || (c3 < best_reg);
    assign nb = take ? c3 : best_reg;
    assign nk = take ? k_reg : bestk_reg;

    mcm_cell #(.COST_BITS(COST_BITS), .DIM_BITS(DIM_BITS), .MUL(1'b1)) u_cell0 (
        .clk(clk), .rst_n(rst_n), .a(COST_BITS'(di_reg)), .b(COST_BITS'(dims_rd_reg)),
        .ovf_in(1'b0), .q_reg(c0), .ovf_reg(v0));
    mcm_cell #(.COST_BITS(COST_BITS), .DIM_BITS(DIM_BITS), .MUL(1'b1)) u_cell1 (
        .clk(clk), .rst_n(rst_n), .a(c0), .b(COST_BITS'(dj_reg)),
        .ovf_in(v0), .q_reg(c1), .ovf_reg(v1));
    mcm_cell #(.COST_BITS(COST_BITS), .DIM_BITS(DIM_BITS), .MUL(1'b0)) u_cell2 (
        .clk(clk), .rst_n(rst_n), .a(c1), .b(ca_rd_reg),
        .ovf_in(v1), .q_reg(c2), .ovf_reg(v2));
    mcm_cell #(.COST_BITS(COST_BITS), .DIM_BITS(DIM_BITS), .MUL(1'b0)) u_cell3 (
        .clk(clk), .rst_n(rst_n), .a(c2), .b(cb_rd_reg),
        .ovf_in(v2), .q_reg(c3), .ovf_reg(v3));

    always_comb
    begin
        state_next     = state_reg;
        loaded_next    = loaded_reg;
        len_next       = len_reg;
        ovf_next       = ovf_reg;
        i_next         = i_reg;
        k_next         = k_reg;
        span_next      = span_reg;
        cnt_next       = cnt_reg;
        di_next        = di_reg;
        dj_next        = dj_reg;
        best_next      = best_reg;
        bestk_next     = bestk_reg;
        single_next    = single_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        out_cost_next  = out_cost_reg;
        out_split_next = out_split_reg;
        out_sat_next   = out_sat_reg;
        out_bad_next   = out_bad_reg;
        dims_we        = 1'b0;
        dims_re        = 1'b0;
        dims_ra        = '0;
        t_we           = 1'b0;
        t_re           = 1'b0;
        t_wa           = '0;
        t_ra           = '0;
        t_rb           = '0;
        t_wcost        = '0;
        t_wsplit       = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (in_ch.cmd == CMD_LOAD))
                begin
                    dims_we     = (int'(loaded_reg) < NDIMS);
                    loaded_next = cnt_new;
                    if (in_ch.last)
                    begin
                        ovf_next    = 1'b0;
                        loaded_next = '0;
                        if (cnt_new < IW'(2))
                        begin
                            len_next       = '0;
                            out_valid_next = 1'b1;
                            out_cost_next  = '0;
                            out_split_next = '0;
                            out_sat_next   = 1'b0;
                            out_bad_next   = 1'b1;
                        end
                        else
                        begin
                            len_next   = cnt_new - IW'(1);
                            i_next     = IW'(1);
                            state_next = ST_DIAG;
                        end
                    end
                end
                else if (accept)
                begin
                    if (qbad)
                    begin
                        out_valid_next = 1'b1;
                        out_cost_next  = '0;
                        out_split_next = '0;
                        out_sat_next   = ovf_reg;
                        out_bad_next   = 1'b1;
                    end
                    else
                    begin
                        t_re        = 1'b1;
                        t_ra        = tidx(qa, qb);
                        single_next = (qa == qb);
                        state_next  = ST_OUT;
                    end
                end
            end
            ST_DIAG:
            begin
                t_we = 1'b1;
                t_wa = tidx(i_reg, i_reg);
                if (i_reg == len_reg)
                begin
                    span_next  = IW'(2);
                    i_next     = IW'(1);
                    k_next     = IW'(1);
                    if (len_reg == IW'(1))
                    begin
                        state_next = ST_ANS;
                    end
                    else
                    begin
                        state_next = ST_RDI;
                    end
                end
                else
                begin
                    i_next = i_reg + IW'(1);
                end
            end
            ST_RDI:
            begin
                dims_re    = 1'b1;
                dims_ra    = DW'(i_reg - IW'(1));
                state_next = ST_RDJ;
            end
            ST_RDJ:
            begin
                di_next    = dims_rd_reg;
                dims_re    = 1'b1;
                dims_ra    = DW'(j_cur);
                state_next = ST_LATJ;
            end
            ST_LATJ:
            begin
                dj_next    = dims_rd_reg;
                state_next = ST_RDK;
            end
            ST_RDK:
            begin
                dims_re    = 1'b1;
                dims_ra    = DW'(k_reg);
                t_re       = 1'b1;
                t_ra       = tidx(i_reg, k_reg);
                t_rb       = tidx(k_reg + IW'(1), j_cur);
                cnt_next   = '0;
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                ovf_next   = ovf_reg | v3;
                best_next  = nb;
                bestk_next = nk;
                if (k_reg + IW'(1) == j_cur)
                begin
                    t_we     = 1'b1;
                    t_wa     = tidx(i_reg, j_cur);
                    t_wcost  = nb;
                    t_wsplit = SW'(nk);
                    if (i_end > {1'b0, len_reg})
                    begin
                        if (span_reg == len_reg)
                        begin
                            state_next = ST_ANS;
                        end
                        else
                        begin
                            span_next  = span_reg + IW'(1);
                            i_next     = IW'(1);
                            k_next     = IW'(1);
                            state_next = ST_RDI;
                        end
                    end
                    else
                    begin
                        i_next     = i_reg + IW'(1);
                        k_next     = i_reg + IW'(1);
                        state_next = ST_RDI;
                    end
                end
                else
                begin
                    k_next     = k_reg + IW'(1);
                    state_next = ST_RDK;
                end
            end
            ST_ANS:
            begin
                t_re        = 1'b1;
                t_ra        = tidx(IW'(1), len_reg);
                single_next = 1'b0;
                state_next  = ST_OUT;
            end
            ST_OUT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_cost_next  = ca_rd_reg;
                    out_split_next = single_reg ? '0 : QIDX_W'(split_rd_reg);
                    out_sat_next   = ovf_reg;
                    out_bad_next   = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            loaded_reg    <= '0;
            len_reg       <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            i_reg         <= '0;
            k_reg         <= '0;
            span_reg      <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            loaded_reg    <= loaded_next;
            len_reg       <= len_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
            i_reg         <= i_next;
            k_reg         <= k_next;
            span_reg      <= span_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        di_reg        <= di_next;
        dj_reg        <= dj_next;
        best_reg      <= best_next;
        bestk_reg     <= bestk_next;
        single_reg    <= single_next;
        out_cost_reg  <= out_cost_next;
        out_split_reg <= out_split_next;
        out_sat_reg   <= out_sat_next;
        out_bad_reg   <= out_bad_next;
    end

    always_ff @(posedge clk)
    begin
        if (dims_we)
        begin
            dims_mem[DW'(loaded_reg)] <= in_ch.dim;
        end
        if (dims_re)
        begin
            dims_rd_reg <= dims_mem[dims_ra];
        end
    end

    always_ff @(posedge clk)
    begin
        if (t_we)
        begin
            cost_mem[t_wa]  <= t_wcost;
            split_mem[t_wa] <= t_wsplit;
        end
        if (t_re)
        begin
            ca_rd_reg    <= cost_mem[t_ra];
            cb_rd_reg    <= cost_mem[t_rb];
            split_rd_reg <= split_mem[t_ra];
        end
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.cost      = out_cost_reg;
    assign out_ch.split     = out_split_reg;
    assign out_ch.saturated = out_sat_reg;
    assign out_ch.bad_query = out_bad_reg;

endmodule

// ===== rtl/core/mcm_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Matrix chain order saturating cell
// One registered saturating multiply or add; cells chain to form a candidate.
// ----------------------------------------------------------------------------
module mcm_cell #(
    parameter int COST_BITS = mcm_pkg::COST_BITS_DEF,
    parameter int DIM_BITS  = mcm_pkg::DIM_BITS_DEF,
    parameter bit MUL       = 1'b0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [COST_BITS-1:0] a,
    input  logic [COST_BITS-1:0] b,
    input  logic                 ovf_in,
    output logic [COST_BITS-1:0] q_reg,
    output logic                 ovf_reg
);
    import mcm_pkg::*;

    logic [COST_BITS-1:0] q_next;
    logic                 sat;

    generate
        if (MUL)
        begin : g_mul
            logic [COST_BITS+DIM_BITS-1:0] prod;
            assign prod   = a * b[DIM_BITS-1:0];
            assign sat    = |prod[COST_BITS+DIM_BITS-1:COST_BITS];
            assign q_next = sat ? {COST_BITS{1'b1}} : prod[COST_BITS-1:0];
        end
        else
        begin : g_add
            logic [COST_BITS:0] sum;
            assign sum    = {1'b0, a} + {1'b0, b};
            assign sat    = sum[COST_BITS];
            assign q_next = sat ? {COST_BITS{1'b1}} : sum[COST_BITS-1:0];
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovf_reg <= 1'b0;
        end
        else
        begin
            ovf_reg <= sat | ovf_in;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

endmodule

// ===== rtl/core/mcm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Matrix chain order port checker
// Watches the top-level channels for result holding and response rules.
// ----------------------------------------------------------------------------
module mcm_checker #(
    parameter int COST_BITS = mcm_pkg::COST_BITS_DEF
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         in_cmd,
    input logic [mcm_pkg::QIDX_W-1:0]   in_first,
    input logic [mcm_pkg::QIDX_W-1:0]   in_end,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [COST_BITS-1:0]         out_cost,
    input logic [mcm_pkg::QIDX_W-1:0]   out_split,
    input logic                         out_bad
);
    import mcm_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_cost) && $stable(out_split))
        else $error("result dropped or changed while stalled");

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_bad |-> (out_cost == '0) && (out_split == '0))
        else $error("rejected request carries a cost or split");

    a_slot: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid || out_ready)
        else $error("request taken while result slot is full");

    a_reject: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_cmd == CMD_QUERY)
        && ((in_first > in_end) || (in_first == '0)) |=> out_valid && out_bad)
        else $error("reversed query not rejected");

endmodule

bind matrix_chain_order_dp mcm_checker #(.COST_BITS(COST_BITS)) u_mcm_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_ch.valid),
    .in_ready(in_ch.ready),
    .in_cmd(in_ch.cmd),
    .in_first(in_ch.chain_first),
    .in_end(in_ch.chain_end),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .out_cost(out_ch.cost),
    .out_split(out_ch.split),
    .out_bad(out_ch.bad_query)
);

// ===== test/matrix_chain_order_dp_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Matrix chain order testbench
// Loads dimension chains and sends subchain queries through the request
// channel. A local interval program predicts each cost and split, and the
// results are checked in order against that prediction. Both channels stall at
// random in the first two of three phases; marked requests wait for the block to drain.
// ----------------------------------------------------------------------------
module matrix_chain_order_dp_test;
    import mcm_pkg::*;

    localparam int NMAT   = MAX_MATRICES_DEF;
    localparam int DBITS  = DIM_BITS_DEF;
    localparam int CBITS  = COST_BITS_DEF;
    localparam logic [63:0] COST_TOP = (64'd1 << CBITS) - 64'd1;
    localparam int N_ITEMS = 1550;

    typedef struct {
        cmd_t                cmd;
        logic [DBITS-1:0]    dim;
        logic                last;
        logic [QIDX_W-1:0]   first_idx;
        logic [QIDX_W-1:0]   end_idx;
        bit                  drain;
    } request_t;

    typedef struct {
        logic [CBITS-1:0]    cost;
        logic [QIDX_W-1:0]   split;
        logic                saturated;
        logic                bad_query;
    } answer_t;

    logic clk;
    logic rst_n;

    mcm_in_if  #(.DIM_BITS(DBITS))  in_ch ();
    mcm_out_if #(.COST_BITS(CBITS)) out_ch ();

    matrix_chain_order_dp dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    request_t request_q[$];
    answer_t  answer_q[$];
    int       total_requests;
    int       issued;
    int       accepted;
    int       checked;
    int       failures;
    int       chains_done;
    int       queries_done;
    int       send_idle_pct;
    int       recv_idle_pct;

    // chain state of the predictor
    logic [DBITS-1:0]  dim_mem[NMAT+1];
    logic [CBITS-1:0]  cost_tab[1:NMAT][1:NMAT];
    logic [QIDX_W-1:0] split_tab[1:NMAT][1:NMAT];
    int                dims_loaded;
    int                chain_size;
    bit                clipped;

    always #5 clk = ~clk;

    function automatic logic [63:0] clip_mul(logic [63:0] a, logic [63:0] b);
        logic [127:0] p;
        p = a * b;
        if (p > COST_TOP)
        begin
            clipped = 1'b1;
            return COST_TOP;
        end
        return p[63:0];
    endfunction

    function automatic logic [63:0] clip_add(logic [63:0] a, logic [63:0] b);
        logic [64:0] s;
        s = a + b;
        if (s > COST_TOP)
        begin
            clipped = 1'b1;
            return COST_TOP;
        end
        return s[63:0];
    endfunction

    function automatic void fill_cost_tables(int n);
        logic [63:0] best;
        logic [63:0] q;
        int          best_k;
        int          j;
        for (int i = 1; i <= n; i++)
        begin
            cost_tab[i][i]  = '0;
            split_tab[i][i] = '0;
        end
        for (int len = 2; len <= n; len++)
        begin
            for (int i = 1; i + len - 1 <= n; i++)
            begin
                j = i + len - 1;
                best = '0;
                best_k = 0;
                for (int k = i; k < j; k++)
                begin
                    q = clip_mul(clip_mul(dim_mem[i-1], dim_mem[k]), dim_mem[j]);
                    q = clip_add(q, cost_tab[i][k]);
                    q = clip_add(q, cost_tab[k+1][j]);
                    if (k == i || q < best)
                    begin
                        best = q;
                        best_k = k;
                    end
                end
                cost_tab[i][j]  = best[CBITS-1:0];
                split_tab[i][j] = QIDX_W'(best_k);
            end
        end
    endfunction

    function automatic answer_t subchain_answer(int a, int b);
        answer_t r;
        r.cost      = cost_tab[a][b];
        r.split     = (a == b) ? '0 : split_tab[a][b];
        r.saturated = clipped;
        r.bad_query = 1'b0;
        return r;
    endfunction

    function automatic answer_t rejected_answer();
        answer_t r;
        r.cost      = '0;
        r.split     = '0;
        r.saturated = clipped;
        r.bad_query = 1'b1;
        return r;
    endfunction

    // returns 1 and the answer when the request produces one
    function automatic bit predict_request(request_t rq, output answer_t r);
        int a;
        int b;
        if (rq.cmd == CMD_LOAD)
        begin
            if (dims_loaded < NMAT + 1)
            begin
                dim_mem[dims_loaded] = rq.dim;
                dims_loaded++;
            end
            if (!rq.last)
                return 0;
            clipped = 1'b0;
            chains_done++;
            if (dims_loaded < 2)
            begin
                chain_size = 0;
                dims_loaded = 0;
                r = rejected_answer();
                return 1;
            end
            chain_size = dims_loaded - 1;
            dims_loaded = 0;
            fill_cost_tables(chain_size);
            r = subchain_answer(1, chain_size);
            return 1;
        end
        queries_done++;
        a = rq.first_idx;
        b = rq.end_idx;
        if (chain_size == 0 || a < 1 || b > chain_size || a > b)
            r = rejected_answer();
        else
            r = subchain_answer(a, b);
        return 1;
    endfunction

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH %0t result %0d %s: got %0h expected %0h",
                 $time, checked, field, got, want);
        failures++;
    endtask

    function automatic void add_request(cmd_t c, int d, bit l, int a, int b, bit drain);
        request_t rq;
        rq.cmd       = c;
        rq.dim       = DBITS'(d);
        rq.last      = l;
        rq.first_idx = QIDX_W'(a);
        rq.end_idx   = QIDX_W'(b);
        rq.drain     = drain;
        request_q.push_back(rq);
    endfunction

    function automatic int pick_dim();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 1;
        if (r == 1)
            return (1 << DBITS) - 1;
        return $urandom_range(1, (1 << DBITS) - 1);
    endfunction

    // dimension count = matrices + 1
    function automatic void add_chain(int n_dims, bit drain);
        for (int i = 0; i < n_dims; i++)
            add_request(CMD_LOAD, pick_dim(), i == n_dims - 1, $urandom_range(0, 31),
                        $urandom_range(0, 31), drain && i == 0);
    endfunction

    function automatic void add_query(int n_mat);
        int a;
        int b;
        if (n_mat < 1 || $urandom_range(0, 6) == 0)
        begin
            add_request(CMD_QUERY, $urandom_range(0, (1 << DBITS) - 1),
                        $urandom_range(0, 1) == 1,
                        $urandom_range(0, 31), $urandom_range(0, 31), 0);
            return;
        end
        a = $urandom_range(1, n_mat);
        b = $urandom_range(a, n_mat);
        add_request(CMD_QUERY, $urandom_range(0, (1 << DBITS) - 1),
                    $urandom_range(0, 1) == 1, a, b, 0);
    endfunction

    // request stimulus
    initial
    begin
        int n_mat;
        int r;
        int n_chains;
        clk = 1'b0;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.cmd = CMD_LOAD;
        in_ch.dim = '0;
        in_ch.last = 1'b0;
        in_ch.chain_first = '0;
        in_ch.chain_end = '0;
        out_ch.ready = 1'b0;
        issued = 0;
        accepted = 0;
        checked = 0;
        failures = 0;
        chains_done = 0;
        queries_done = 0;
        dims_loaded = 0;
        chain_size = 0;
        clipped = 1'b0;
        send_idle_pct = 21;
        recv_idle_pct = 55;

        // query with no chain, single dimension chain
        add_request(CMD_QUERY, 0, 0, 1, 1, 0);
        add_request(CMD_LOAD, 4095, 1, 31, 31, 0);
        // one matrix, extreme dimensions
        add_request(CMD_LOAD, 1, 0, 0, 0, 0);
        add_request(CMD_LOAD, 4095, 1, 0, 0, 0);
        add_request(CMD_QUERY, 4095, 1, 1, 1, 0);
        // equal dimensions: every split ties
        for (int i = 0; i < 4; i++)
            add_request(CMD_LOAD, 7, i == 3, 0, 0, 0);
        add_request(CMD_QUERY, 0, 0, 1, 3, 0);
        add_request(CMD_QUERY, 0, 0, 3, 1, 0);
        add_request(CMD_QUERY, 0, 0, 0, 2, 0);
        add_request(CMD_QUERY, 0, 0, 2, 4, 0);
        // too many dimensions, then a full chain of largest dimensions
        for (int i = 0; i < 19; i++)
            add_request(CMD_LOAD, 4095 - i, i == 18, 0, 0, 0);
        add_request(CMD_QUERY, 0, 0, 1, 16, 0);
        add_request(CMD_QUERY, 0, 0, 16, 16, 0);
        add_request(CMD_QUERY, 0, 0, 31, 31, 1);

        n_chains = 0;
        while (request_q.size() < N_ITEMS)
        begin
            r = $urandom_range(0, 99);
            if (r < 3)
                n_mat = NMAT;
            else if (r < 5)
                n_mat = NMAT + $urandom_range(1, 2);
            else if (r < 8)
                n_mat = 0;
            else
                n_mat = $urandom_range(1, 6);
            if ($urandom_range(0, 9) == 0)
                add_query(0);
            add_chain(n_mat + 1, n_chains % 40 == 7);
            n_chains++;
            if (n_mat > NMAT)
                n_mat = NMAT;
            r = $urandom_range(0, 5);
            for (int q = 0; q < r; q++)
                add_query(n_mat);
        end
        total_requests = request_q.size();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
    end

    // request driver
    always @(negedge clk)
    begin
        bit send;
        send = 0;
        if (rst_n)
        begin
            send_idle_pct = (issued < total_requests / 3) ? 21 :
                            (issued < 2 * total_requests / 3) ? 55 : 0;
            recv_idle_pct = (issued < total_requests / 3) ? 55 :
                            (issued < 2 * total_requests / 3) ? 21 : 0;
            if (issued == accepted && request_q.size() > 0
                && !(request_q[0].drain && answer_q.size() != 0)
                && $urandom_range(0, 99) >= send_idle_pct)
                send = 1;
            if (send)
            begin
                request_t rq;
                rq = request_q.pop_front();
                in_ch.cmd <= rq.cmd;
                in_ch.dim <= rq.dim;
                in_ch.last <= rq.last;
                in_ch.chain_first <= rq.first_idx;
                in_ch.chain_end <= rq.end_idx;
                in_ch.valid <= 1'b1;
                issued++;
            end
            else if (issued == accepted)
                in_ch.valid <= 1'b0;
            out_ch.ready <= $urandom_range(0, 99) >= recv_idle_pct;
        end
    end

    // result checker and predictor
    always @(posedge clk)
    begin
        answer_t want;
        answer_t got;
        request_t rq;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got.cost = out_ch.cost;
            got.split = out_ch.split;
            got.saturated = out_ch.saturated;
            got.bad_query = out_ch.bad_query;
            if (answer_q.size() == 0)
                report_mismatch("unexpected result", got.cost, 0);
            else
            begin
                want = answer_q.pop_front();
                if (got.cost !== want.cost)
                    report_mismatch("cost", got.cost, want.cost);
                if (got.split !== want.split)
                    report_mismatch("split", got.split, want.split);
                if (got.saturated !== want.saturated)
                    report_mismatch("saturated", got.saturated, want.saturated);
                if (got.bad_query !== want.bad_query)
                    report_mismatch("bad_query", got.bad_query, want.bad_query);
            end
            checked++;
        end
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            rq.cmd = cmd_t'(in_ch.cmd);
            rq.dim = in_ch.dim;
            rq.last = in_ch.last;
            rq.first_idx = in_ch.chain_first;
            rq.end_idx = in_ch.chain_end;
            rq.drain = 0;
            if (predict_request(rq, want))
                answer_q.push_back(want);
            accepted++;
        end
    end

    initial
    begin
        wait (rst_n === 1'b1);
        wait (request_q.size() == 0 && issued == accepted);
        wait (answer_q.size() == 0);
        repeat (40) @(posedge clk);
        $display("Covered %0d requests: %0d chains computed, %0d queries, %0d results checked.",
                 accepted, chains_done, queries_done, checked);
        if (failures == 0 && answer_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #8ms;
        $display("TIMEOUT after %0t", $time);
        $display("Some tests failed");
        $finish;
    end

endmodule
